FILE: rtl/dtb_pkg.sv
// package: shared constants, codes and beat types for the deadline timer bank
package dtb_pkg;

  localparam int COMPONENTS = 8;
  localparam int TIME_W     = 64;
  localparam int UNIT_W     = 4;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 3;

  localparam logic [FUNC_W-1:0] FUNC_ARM_TX  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ARM_RX  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_INVALID = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ARMED      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RX_TIMEOUT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TX_TIMEOUT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BUSY       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD        = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [UNIT_W-1:0] component;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [UNIT_W-1:0] unit;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic              arm_rx;
    logic              arm_tx;
    logic [TIME_W-1:0] deadline;
  } cell_ctl_t;

  typedef struct packed {
    logic run_rx;
    logic run_tx;
    logic tok_rx;
    logic tok_tx;
    logic hit_rx;
    logic hit_tx;
  } cell_stat_t;

endpackage

FILE: rtl/dtb_cell.sv
// cell: receive and transmit timer of one component, with its slice of the scan chain
module dtb_cell import dtb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [TIME_W-1:0] now,
  input  logic              tok_in,
  output logic              tok_out,
  output cell_stat_t        stat
);

  logic [TIME_W-1:0] dl_rx_r;
  logic [TIME_W-1:0] dl_tx_r;
  logic              run_rx_r, run_rx_nxt;
  logic              run_tx_r, run_tx_nxt;
  logic              tok_rx_r;
  logic              tok_tx_r;
  logic              hit_rx;
  logic              hit_tx;

  assign hit_rx = tok_rx_r & run_rx_r & (now >= dl_rx_r);
  assign hit_tx = tok_tx_r & run_tx_r & (now >= dl_tx_r);

  always_comb begin
    run_rx_nxt = run_rx_r;
    run_tx_nxt = run_tx_r;
    if (ctl.arm_rx) begin
      run_rx_nxt = 1'b1;
    end else if (hit_rx) begin
      run_rx_nxt = 1'b0;
    end
    if (ctl.arm_tx) begin
      run_tx_nxt = 1'b1;
    end else if (hit_tx) begin
      run_tx_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_rx_r <= 1'b0;
      run_tx_r <= 1'b0;
      tok_rx_r <= 1'b0;
      tok_tx_r <= 1'b0;
    end else begin
      run_rx_r <= run_rx_nxt;
      run_tx_r <= run_tx_nxt;
      tok_rx_r <= tok_in;
      tok_tx_r <= tok_rx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.arm_rx) begin
      dl_rx_r <= ctl.deadline;
    end
    if (ctl.arm_tx) begin
      dl_tx_r <= ctl.deadline;
    end
  end

  assign tok_out     = tok_tx_r;
  assign stat.run_rx = run_rx_r;
  assign stat.run_tx = run_tx_r;
  assign stat.tok_rx = tok_rx_r;
  assign stat.tok_tx = tok_tx_r;
  assign stat.hit_rx = hit_rx;
  assign stat.hit_tx = hit_tx;

endmodule

FILE: rtl/deadline_timer_bank_top.sv
// top level: deadline timer bank with request decode, scan chain and result register
// An arm request (receive or transmit) or an invalid request is taken while busy is low and
// its single result appears with out_valid in the next cycle; busy does not rise for it.
// A tick raises busy until a token has walked the row of cells, one timer per cycle, receive
// before transmit, and each compare with the tick time is done in the cell that holds
// the token. Timeout results follow in scan order, one per cycle at most, each held in
// a pending register until the next one or the scan end, so the final one carries last;
// the final beat comes out in the cycle busy falls. out_valid marks each beat for exactly
// one cycle and cannot be held off, so the receiver must take every beat as it comes.
module deadline_timer_bank_top import dtb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  cell_ctl_t  ctl   [COMPONENTS];
  cell_stat_t stat  [COMPONENTS];
  logic       tok   [COMPONENTS+1];
  logic [2*COMPONENTS-1:0] tok_vec;
  logic [COMPONENTS-1:0]   sel;
  logic [COMPONENTS-1:0]   run_rx_vec;
  logic [COMPONENTS-1:0]   run_tx_vec;
  logic [COMPONENTS-1:0]   hit_rx_vec;
  logic [COMPONENTS-1:0]   hit_tx_vec;

  logic              accept;
  logic              is_arm_rx;
  logic              is_arm_tx;
  logic              sel_busy;
  logic              hit_any;
  logic [UNIT_W-1:0] hit_unit;
  logic [KIND_W-1:0] hit_kind;
  logic              scan_end;

  logic              busy_r, busy_nxt;
  logic              flush_r;
  logic [TIME_W-1:0] now_r;
  logic              pend_v_r, pend_v_nxt;
  logic [KIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic [UNIT_W-1:0] pend_unit_r, pend_unit_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  assign accept    = start & ~busy_r;
  assign is_arm_rx = (in_beat.func == FUNC_ARM_RX);
  assign is_arm_tx = (in_beat.func == FUNC_ARM_TX);
  assign tok[0]    = accept & (in_beat.func == FUNC_TICK);
  assign scan_end  = tok[COMPONENTS];

  for (genvar i = 0; i < COMPONENTS; i++) begin : g_cell
    assign sel[i]            = (in_beat.component == UNIT_W'(i));
    assign ctl[i].arm_rx     = accept & is_arm_rx & sel[i] & ~stat[i].run_rx;
    assign ctl[i].arm_tx     = accept & is_arm_tx & sel[i] & ~stat[i].run_tx;
    assign ctl[i].deadline   = in_beat.deadline;
    assign run_rx_vec[i]     = stat[i].run_rx;
    assign run_tx_vec[i]     = stat[i].run_tx;
    assign hit_rx_vec[i]     = stat[i].hit_rx;
    assign hit_tx_vec[i]     = stat[i].hit_tx;
    assign tok_vec[2*i]      = stat[i].tok_rx;
    assign tok_vec[2*i+1]    = stat[i].tok_tx;

    dtb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .now     (now_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .stat    (stat[i])
    );
  end

  assign sel_busy = is_arm_rx ? |(sel & run_rx_vec) : |(sel & run_tx_vec);
  assign hit_any  = |(hit_rx_vec | hit_tx_vec);
  assign hit_kind = (|hit_rx_vec) ? KIND_RX_TIMEOUT : KIND_TX_TIMEOUT;

  always_comb begin
    hit_unit = '0;
    for (int i = 0; i < COMPONENTS; i++) begin
      if (hit_rx_vec[i] | hit_tx_vec[i]) begin
        hit_unit = hit_unit | UNIT_W'(i);
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_unit_nxt = pend_unit_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = '0;
    if (accept) begin
      out_beat_nxt.unit = in_beat.component;
      out_beat_nxt.last = 1'b1;
      case (in_beat.func)
        FUNC_ARM_TX, FUNC_ARM_RX: begin
          out_valid_nxt = 1'b1;
          if (|sel) begin
            out_beat_nxt.kind = sel_busy ? KIND_BUSY : KIND_ARMED;
          end else begin
            out_beat_nxt.kind = KIND_BAD;
          end
        end
        FUNC_TICK: begin
          busy_nxt     = 1'b1;
          out_beat_nxt = '0;
        end
        default: begin
          out_valid_nxt     = 1'b1;
          out_beat_nxt.kind = KIND_BAD;
        end
      endcase
    end
    // hold each timeout until the next one or the scan end so the final one can be marked
    if (hit_any) begin
      if (pend_v_r) begin
        out_valid_nxt      = 1'b1;
        out_beat_nxt.kind  = pend_kind_r;
        out_beat_nxt.unit  = pend_unit_r;
        out_beat_nxt.stamp = now_r;
        out_beat_nxt.last  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = hit_kind;
      pend_unit_nxt = hit_unit;
    end
    if (flush_r) begin
      busy_nxt = 1'b0;
      if (pend_v_r) begin
        out_valid_nxt      = 1'b1;
        out_beat_nxt.kind  = pend_kind_r;
        out_beat_nxt.unit  = pend_unit_r;
        out_beat_nxt.stamp = now_r;
        out_beat_nxt.last  = 1'b1;
        pend_v_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      flush_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      flush_r     <= scan_end;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_unit_r <= pend_unit_nxt;
    out_beat_r  <= out_beat_nxt;
    if (tok[0]) begin
      now_r <= in_beat.now;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vec) <= 1)
    else $error("more than one scan token in the chain");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_vec == '0) && !pend_v_r)
    else $error("scan activity while idle");

  a_req_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_beat.func != FUNC_TICK) |=> (out_valid && out_beat.last))
    else $error("request beat without a single final result");

  a_timeout_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_beat.kind == KIND_RX_TIMEOUT || out_beat.kind == KIND_TX_TIMEOUT))
      |-> (out_beat.stamp == now_r))
    else $error("timeout beat stamp differs from tick time");

endmodule

FILE: sim/deadline_timer_bank_checker.sv
`timescale 1ns / 1ps
// checker: timer bank predictor and result beat comparison for the deadline timer bank
module deadline_timer_bank_checker import dtb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_beat,
  input  logic      out_valid,
  input  out_beat_t out_beat,
  output int        mismatches,
  output int        owed
);

  localparam int SLOT_W = $clog2(COMPONENTS);

  logic [TIME_W-1:0]     rx_due [COMPONENTS];
  logic [TIME_W-1:0]     tx_due [COMPONENTS];
  logic [COMPONENTS-1:0] rx_live = '0;
  logic [COMPONENTS-1:0] tx_live = '0;
  out_beat_t             owed_results[$];
  int                    fail_count = 0;
  int                    owed_count = 0;

  assign mismatches = fail_count;
  assign owed       = owed_count;

  task automatic predict_request(input in_beat_t req);
    out_beat_t         r;
    out_beat_t         held;
    logic              have_held;
    logic              running;
    logic [SLOT_W-1:0] slot;
    r = '0;
    held = '0;
    have_held = 1'b0;
    case (req.func)
      FUNC_ARM_TX, FUNC_ARM_RX: begin
        r.unit = req.component;
        r.last = 1'b1;
        if (int'(req.component) >= COMPONENTS) begin
          r.kind = KIND_BAD;
        end else begin
          slot = SLOT_W'(req.component);
          running = (req.func == FUNC_ARM_RX) ? rx_live[slot] : tx_live[slot];
          if (running) begin
            r.kind = KIND_BUSY;
          end else begin
            r.kind = KIND_ARMED;
            if (req.func == FUNC_ARM_RX) begin
              rx_due[slot]  = req.deadline;
              rx_live[slot] = 1'b1;
            end else begin
              tx_due[slot]  = req.deadline;
              tx_live[slot] = 1'b1;
            end
          end
        end
        owed_results.push_back(r);
      end
      FUNC_TICK: begin
        // scan receive before transmit; the final expiry carries last
        for (int i = 0; i < COMPONENTS; i++) begin
          if (rx_live[i] && req.now >= rx_due[i]) begin
            rx_live[i] = 1'b0;
            if (have_held) owed_results.push_back(held);
            held.kind  = KIND_RX_TIMEOUT;
            held.unit  = UNIT_W'(i);
            held.stamp = req.now;
            held.last  = 1'b0;
            have_held  = 1'b1;
          end
          if (tx_live[i] && req.now >= tx_due[i]) begin
            tx_live[i] = 1'b0;
            if (have_held) owed_results.push_back(held);
            held.kind  = KIND_TX_TIMEOUT;
            held.unit  = UNIT_W'(i);
            held.stamp = req.now;
            held.last  = 1'b0;
            have_held  = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          owed_results.push_back(held);
        end
      end
      default: begin
        r.kind = KIND_BAD;
        r.unit = req.component;
        r.last = 1'b1;
        owed_results.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      rx_live = '0;
      tx_live = '0;
      owed_results.delete();
    end else begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: kind %0d unit %0d stamp %h last %0d",
                 out_beat.kind, out_beat.unit, out_beat.stamp, out_beat.last);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_beat.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_beat.kind);
            fail_count++;
          end
          if (out_beat.unit !== want.unit) begin
            $error("unit: expected %0d, got %0d", want.unit, out_beat.unit);
            fail_count++;
          end
          if (out_beat.stamp !== want.stamp) begin
            $error("stamp: expected %h, got %h", want.stamp, out_beat.stamp);
            fail_count++;
          end
          if (out_beat.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_beat.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_request(in_beat);
    end
    owed_count = owed_results.size();
  end

endmodule

FILE: sim/deadline_timer_bank_top_tb.sv
`timescale 1ns / 1ps
// testbench top: reset, request stimulus, watchdog and verdict for the deadline timer bank
module deadline_timer_bank_top_tb;
  import dtb_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 2 * COMPONENTS + 4;
  localparam int RANDOM_BEATS = 480;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;
  int        mismatches;
  int        owed;
  int        quiet_cycles = 0;
  int        idle_pct = 0;
  logic [TIME_W-1:0] wall = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deadline_timer_bank_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  deadline_timer_bank_checker timer_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_beat   (out_beat),
    .mismatches (mismatches),
    .owed       (owed)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("deadline_timer_bank_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [UNIT_W-1:0] c,
                       input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] t);
    in_beat_t b;
    b.func      = f;
    b.component = c;
    b.deadline  = dl;
    b.now       = t;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_results;
    start <= 1'b0;
    @(negedge clk);
    while (owed != 0 || busy) @(negedge clk);
  endtask

  task automatic random_request;
    int                pick;
    logic [UNIT_W-1:0] c;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(0, 99);
    c    = UNIT_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) c = UNIT_W'(c % COMPONENTS);
    if ($urandom_range(0, 9) == 0) dl = {$urandom, $urandom};
    else dl = wall + TIME_W'($urandom_range(0, 48));
    t = {$urandom, $urandom};
    if (pick < 25) begin
      issue(FUNC_ARM_TX, c, dl, t);
    end else if (pick < 50) begin
      issue(FUNC_ARM_RX, c, dl, t);
    end else if (pick < 85) begin
      wall = wall + TIME_W'($urandom_range(0, 24));
      case ($urandom_range(0, 24))
        0:       t = '1;
        1:       t = {$urandom, $urandom};
        default: t = wall;
      endcase
      issue(FUNC_TICK, c, {$urandom, $urandom}, t);
    end else if (pick < 93) begin
      issue(FUNC_INVALID, UNIT_W'($urandom_range(0, 15)), {$urandom, $urandom}, t);
    end else begin
      issue($urandom_range(0, 1) ? FUNC_ARM_RX : FUNC_ARM_TX,
            UNIT_W'($urandom_range(COMPONENTS, 15)), dl, t);
    end
  endtask

  initial begin
    wall = {$urandom, $urandom};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue(FUNC_TICK, 4'd0, '0, '0);
    issue(FUNC_ARM_TX, 4'd0, '0, '1);
    issue(FUNC_ARM_RX, 4'd0, '1, '0);
    issue(FUNC_ARM_TX, 4'd0, 64'd9, '0);
    issue(FUNC_ARM_RX, 4'd0, 64'd9, '0);
    issue(FUNC_ARM_RX, UNIT_W'(COMPONENTS - 1), 64'd5, '0);
    issue(FUNC_ARM_TX, UNIT_W'(COMPONENTS - 1), 64'd5, '0);
    issue(FUNC_ARM_TX, UNIT_W'(COMPONENTS), 64'd3, '0);
    issue(FUNC_ARM_RX, 4'd15, '1, '1);
    issue(FUNC_INVALID, 4'd3, '1, '1);
    issue(FUNC_INVALID, 4'd15, '0, '0);
    issue(FUNC_TICK, 4'd15, '1, 64'd0);
    issue(FUNC_TICK, 4'd0, '0, 64'd4);
    issue(FUNC_TICK, 4'd0, '0, 64'd5);
    issue(FUNC_ARM_TX, 4'd3, 64'h8000_0000_0000_0000, '0);
    issue(FUNC_ARM_RX, 4'd5, 64'h8000_0000_0000_0000, '0);
    // unsigned compare: just below the msb must not expire
    issue(FUNC_TICK, 4'd0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    issue(FUNC_TICK, 4'd0, '0, '1);
    issue(FUNC_TICK, 4'd0, '0, '1);
    wait_all_results();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      case (n / 120)
        0:       idle_pct = 0;
        1:       idle_pct = 86;
        2:       idle_pct = 22;
        default: idle_pct = ((n % 40) < 20) ? 0 : 86;
      endcase
      if (n == 240) begin
        wait_all_results();
        wall = {$urandom, $urandom};
      end
      random_request();
    end

    wait_all_results();
    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("deadline_timer_bank_top_tb OK");
    end else begin
      $display("deadline_timer_bank_top_tb NOT OK");
    end
    $finish;
  end

endmodule
